/* rtl/range_frame_parser_averager_macros.svh */
// Assertion macros for the range frame parser and averager.
// Included by the top level; no other dependencies.
`ifndef RANGE_FRAME_PARSER_AVERAGER_MACROS_SVH
`define RANGE_FRAME_PARSER_AVERAGER_MACROS_SVH

`ifndef ASSERT_OFF
`define RFPA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define RFPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define RFPA_ASSERT_SAME(label, clk, rst, ante, cons)
`define RFPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/rfpa_pkg.sv */
// Shared types and constants for the range frame parser and averager.
// No dependencies.
package rfpa_pkg;

   localparam int DIGIT_W = 14;
   localparam int QUO_W   = DIGIT_W;
   localparam int STEP_W  = $clog2(QUO_W);
   localparam int DIST_W  = 16;
   localparam int STAT_W  = 2;

   localparam logic [7:0] HEADER_BYTE = 8'h52;
   localparam logic [7:0] CR_BYTE     = 8'h0D;
   localparam logic [7:0] DIGIT_LO    = 8'h30;
   localparam logic [7:0] DIGIT_HI    = 8'h39;

   localparam logic [DIGIT_W-1:0] NO_TARGET_A = 14'd5000;
   localparam logic [DIGIT_W-1:0] NO_TARGET_B = 14'd9999;
   localparam logic [DIST_W-1:0]  NO_TARGET_ADD_MM = 16'd1000;
   localparam logic [DIST_W-1:0]  MAX_RANGE_RESET  = 16'd10000;

   localparam logic OPCODE_BYTE = 1'b0;
   localparam logic OPCODE_POLL = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_NONE      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_MEAN      = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_NO_TARGET = 2'd2;

   typedef struct packed {
      logic take_byte;
      logic capture;
      logic div_step;
      logic load_out;
   } rfpa_cmd_type;

   typedef struct packed {
      logic has_valid;
      logic out_free;
   } rfpa_stat_type;

   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] value;
   } rfpa_frame_type;

endpackage

/* rtl/rfpa_req_if.sv */
// Input channel: received byte or poll, valid/ready handshake.
// No dependencies.
interface rfpa_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] rx_byte;

   modport source(output valid, output opcode, output rx_byte, input ready);
   modport sink(input valid, input opcode, input rx_byte, output ready);
endinterface

/* rtl/rfpa_rsp_if.sv */
// Result channel: status and distance, valid/ready handshake.
// No dependencies.
interface rfpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] distance_mm;

   modport source(output valid, output status, output distance_mm, input ready);
   modport sink(input valid, input status, input distance_mm, output ready);
endinterface

/* rtl/rfpa_parser.sv */
// Frame parser: 'R', four ASCII digits, CR; emits a completed range.
// Depends on rfpa_pkg.
module rfpa_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take_byte,
   input  logic [7:0]            rx_byte,
   output rfpa_pkg::rfpa_frame_type frame
);

   localparam logic [2:0] POS_HEADER = 3'd0;
   localparam logic [2:0] POS_LAST_DIGIT = 3'd4;
   localparam logic [2:0] POS_TERM = 3'd5;

   logic [2:0]                  pos_ff, pos_in;
   logic [rfpa_pkg::DIGIT_W-1:0] digit_ff, digit_in;
   logic                        is_digit;
   logic [rfpa_pkg::DIGIT_W-1:0] digit_x10;
   logic [rfpa_pkg::DIGIT_W-1:0] digit_add;

   assign is_digit  = (rx_byte >= rfpa_pkg::DIGIT_LO) && (rx_byte <= rfpa_pkg::DIGIT_HI);
   assign digit_x10 = {digit_ff[rfpa_pkg::DIGIT_W-4:0], 3'b000}
                    + {digit_ff[rfpa_pkg::DIGIT_W-2:0], 1'b0};
   assign digit_add = {{(rfpa_pkg::DIGIT_W-4){1'b0}}, rx_byte[3:0]};

   always_comb begin
      pos_in     = pos_ff;
      digit_in   = digit_ff;
      frame.done  = 1'b0;
      frame.value = digit_ff;
      if (take_byte) begin
         priority if (pos_ff == POS_HEADER) begin
            if (rx_byte == rfpa_pkg::HEADER_BYTE) begin
               digit_in = '0;
               pos_in   = 3'd1;
            end
         end else if (pos_ff <= POS_LAST_DIGIT) begin
            if (is_digit) begin
               digit_in = digit_x10 + digit_add;
               pos_in   = pos_ff + 3'd1;
            end else begin
               pos_in = POS_HEADER;
            end
         end else if (pos_ff == POS_TERM) begin
            frame.done = (rx_byte == rfpa_pkg::CR_BYTE);
            pos_in     = POS_HEADER;
         end else begin
            pos_in = POS_HEADER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_HEADER;
         digit_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         digit_ff <= digit_in;
      end
   end

endmodule

/* rtl/rfpa_datapath.sv */
// Datapath: batch accumulators, 14-step restoring divider, result register
// and max range register. Depends on rfpa_pkg.
module rfpa_datapath #(
   parameter int MAX_FRAMES_PER_BATCH = 4095
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rfpa_pkg::rfpa_cmd_type   cmd,
   input  rfpa_pkg::rfpa_frame_type frame,
   input  logic                     csr_wr_en,
   input  logic [rfpa_pkg::DIST_W-1:0] csr_wr_data,
   output rfpa_pkg::rfpa_stat_type  stat,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [rfpa_pkg::STAT_W-1:0] rsp_status,
   output logic [rfpa_pkg::DIST_W-1:0] rsp_distance_mm
);

   localparam int CNT_W = $clog2(MAX_FRAMES_PER_BATCH + 1);
   localparam int SUM_W = CNT_W + rfpa_pkg::DIGIT_W;
   localparam int QW    = rfpa_pkg::QUO_W;
   localparam int DW    = rfpa_pkg::DIST_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAMES_PER_BATCH);

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] vcnt_ff, vcnt_in;
   logic [CNT_W-1:0] ntcnt_ff, ntcnt_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] dvsr_ff, dvsr_in;
   logic [rfpa_pkg::STAT_W-1:0] res_status_ff, res_status_in;
   logic [DW-1:0]    max_range_ff, max_range_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [rfpa_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DW-1:0]    rsp_dist_ff, rsp_dist_in;

   logic             is_no_target;
   logic [CNT_W:0]   trial;
   logic [CNT_W:0]   diff;
   logic             trial_ge;
   logic [DW:0]      nt_sum;
   logic [DW-1:0]    nt_dist;
   logic [DW-1:0]    dist_sel;

   assign is_no_target = (frame.value == rfpa_pkg::NO_TARGET_A)
                      || (frame.value == rfpa_pkg::NO_TARGET_B);
   assign trial    = {rem_ff, quo_ff[QW-1]};
   assign diff     = trial - {1'b0, dvsr_ff};
   assign trial_ge = (trial >= {1'b0, dvsr_ff});
   assign nt_sum   = {1'b0, max_range_ff} + {1'b0, rfpa_pkg::NO_TARGET_ADD_MM};
   assign nt_dist  = nt_sum[DW] ? {DW{1'b1}} : nt_sum[DW-1:0];

   always_comb begin
      unique case (res_status_ff)
         rfpa_pkg::STATUS_MEAN:      dist_sel = {{(DW-QW){1'b0}}, quo_ff};
         rfpa_pkg::STATUS_NO_TARGET: dist_sel = nt_dist;
         default:                    dist_sel = '0;
      endcase
   end

   always_comb begin
      sum_in        = sum_ff;
      vcnt_in       = vcnt_ff;
      ntcnt_in      = ntcnt_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dvsr_in       = dvsr_ff;
      res_status_in = res_status_ff;
      max_range_in  = csr_wr_en ? csr_wr_data : max_range_ff;
      rsp_status_in = rsp_status_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (cmd.capture) begin
         // quotient is below 2^14, so the upper sum bits start the remainder
         rem_in   = sum_ff[SUM_W-1:QW];
         quo_in   = sum_ff[QW-1:0];
         dvsr_in  = vcnt_ff;
         sum_in   = '0;
         vcnt_in  = '0;
         ntcnt_in = '0;
         priority if (vcnt_ff != '0) begin
            res_status_in = rfpa_pkg::STATUS_MEAN;
         end else if (ntcnt_ff != '0) begin
            res_status_in = rfpa_pkg::STATUS_NO_TARGET;
         end else begin
            res_status_in = rfpa_pkg::STATUS_NONE;
         end
      end else if (frame.done) begin
         if (is_no_target) begin
            if (ntcnt_ff != CNT_MAX) begin
               ntcnt_in = ntcnt_ff + 1'b1;
            end
         end else if (vcnt_ff != CNT_MAX) begin
            sum_in  = sum_ff + {{CNT_W{1'b0}}, frame.value};
            vcnt_in = vcnt_ff + 1'b1;
         end
      end

      if (cmd.div_step) begin
         rem_in = trial_ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in = {quo_ff[QW-2:0], trial_ge};
      end

      if (cmd.load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_dist_in   = dist_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         vcnt_ff      <= '0;
         ntcnt_ff     <= '0;
         max_range_ff <= rfpa_pkg::MAX_RANGE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         vcnt_ff      <= vcnt_in;
         ntcnt_ff     <= ntcnt_in;
         max_range_ff <= max_range_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dvsr_ff       <= dvsr_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dist_ff   <= rsp_dist_in;
   end

   assign stat.has_valid  = (vcnt_ff != '0);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_distance_mm = rsp_dist_ff;

endmodule

/* rtl/rfpa_ctrl.sv */
// Controller: input handshake, poll sequencing, divider step count.
// Depends on rfpa_pkg.
module rfpa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_opcode,
   output logic                    req_ready,
   input  rfpa_pkg::rfpa_stat_type stat,
   output rfpa_pkg::rfpa_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;
   localparam logic [rfpa_pkg::STEP_W-1:0] STEP_LAST =
      rfpa_pkg::STEP_W'(rfpa_pkg::QUO_W - 1);

   logic [1:0]                  state_ff, state_in;
   logic [rfpa_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd.take_byte = accept && (req_opcode == rfpa_pkg::OPCODE_BYTE);
      cmd.capture   = accept && (req_opcode == rfpa_pkg::OPCODE_POLL);
      cmd.div_step  = 1'b0;
      cmd.load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               step_in  = '0;
               state_in = stat.has_valid ? ST_DIVIDE : ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

/* rtl/range_frame_parser_averager.sv */
// Top level of the range frame parser and averager.
// Depends on rfpa_pkg, rfpa_req_if, rfpa_rsp_if, rfpa_parser, rfpa_ctrl,
// rfpa_datapath and range_frame_parser_averager_macros.svh.

// Received bytes are taken one per cycle, except while a poll is in progress,
// and parsed into frames of 'R', four ASCII digits and CR; ranges of 5000 and
// 9999 mm count as no-target, others are summed. A poll returns one result and
// clears the batch: the truncated mean when valid frames exist, else
// max_range_mm + 1000 (saturated) when no-target frames exist, else status
// "no reading" with distance 0. A poll holds off further input while the mean
// is computed when it is needed (14 steps of a restoring divider, one bit per
// cycle) and while the result register is loaded, longer only while an
// earlier result is still waiting on the result channel. Bytes are still
// taken while a result waits. max_range_mm may be written only while idle.
`include "range_frame_parser_averager_macros.svh"

module range_frame_parser_averager #(
   parameter int MAX_FRAMES_PER_BATCH = 4095
) (
   input  logic        clock,
   input  logic        reset,
   rfpa_req_if.sink    req_ch,
   rfpa_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   rfpa_pkg::rfpa_cmd_type   cmd;
   rfpa_pkg::rfpa_stat_type  stat;
   rfpa_pkg::rfpa_frame_type frame;

   logic poll_xfer;
   logic no_reading_out;
   logic status_legal;

   rfpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rfpa_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take_byte (cmd.take_byte),
      .rx_byte   (req_ch.rx_byte),
      .frame     (frame)
   );

   rfpa_datapath #(
      .MAX_FRAMES_PER_BATCH (MAX_FRAMES_PER_BATCH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .frame           (frame),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .stat            (stat),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_distance_mm (rsp_ch.distance_mm)
   );

   assign poll_xfer      = req_ch.valid && req_ch.ready
                        && (req_ch.opcode == rfpa_pkg::OPCODE_POLL);
   assign no_reading_out = rsp_ch.valid && (rsp_ch.status == rfpa_pkg::STATUS_NONE);
   assign status_legal   = (rsp_ch.status == rfpa_pkg::STATUS_NONE)
                        || (rsp_ch.status == rfpa_pkg::STATUS_MEAN)
                        || (rsp_ch.status == rfpa_pkg::STATUS_NO_TARGET);

   `RFPA_ASSERT_NEXT(a_poll_blocks_input, clock, reset, poll_xfer, !req_ch.ready)
   `RFPA_ASSERT_NEXT(a_load_shows_result, clock, reset, cmd.load_out, rsp_ch.valid)
   `RFPA_ASSERT_SAME(a_no_reading_zero, clock, reset, no_reading_out, rsp_ch.distance_mm == '0)
   `RFPA_ASSERT_SAME(a_status_legal, clock, reset, rsp_ch.valid, status_legal)

endmodule

/* test/rfpa_result_checker.sv */
// Result checker for the range frame parser and averager: watches the request,
// result and register ports, predicts every poll result and compares it.
// Depends on rfpa_pkg, rfpa_req_if and rfpa_rsp_if.
module rfpa_result_checker #(
   parameter int MAX_FRAMES = 4095
) (
   input  logic        clock,
   input  logic        reset,
   rfpa_req_if         req_mon,
   rfpa_rsp_if         rsp_mon,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          mismatches,
   output int          outstanding,
   output int          results_seen,
   output int          mean_results,
   output int          no_target_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [rfpa_pkg::STAT_W-1:0] status;
      logic [rfpa_pkg::DIST_W-1:0] distance_mm;
   } range_result_type;

   localparam logic [2:0] POS_HEADER = 3'd0;
   localparam logic [2:0] POS_CR     = 3'd5;
   localparam int         MAX_PRINTS = 40;

   logic [15:0]                  max_range;
   logic [2:0]                   frame_pos;
   logic [rfpa_pkg::DIGIT_W-1:0] frame_digits;
   logic [25:0]                  batch_sum;
   logic [11:0]                  batch_valid;
   logic [11:0]                  batch_no_target;
   range_result_type             pending_results[$];

   task automatic report_mismatch(input string msg);
      if (mismatches < MAX_PRINTS)
         $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // Advances the frame parser and batch state by one transfer; returns 1 with
   // the result when the transfer is a poll.
   function automatic bit average_batch(input logic op, input logic [7:0] b,
                                        output range_result_type res);
      logic [25:0] quot;
      logic [16:0] capped;
      int          acc;
      res = '0;
      if (op == rfpa_pkg::OPCODE_BYTE) begin
         if (frame_pos == POS_HEADER) begin
            if (b == rfpa_pkg::HEADER_BYTE) begin
               frame_digits = '0;
               frame_pos = 3'd1;
            end
         end else if (frame_pos < POS_CR) begin
            if (b >= rfpa_pkg::DIGIT_LO && b <= rfpa_pkg::DIGIT_HI) begin
               acc = int'(frame_digits) * 10 + int'(b - rfpa_pkg::DIGIT_LO);
               frame_digits = acc[rfpa_pkg::DIGIT_W-1:0];
               frame_pos = frame_pos + 3'd1;
            end else begin
               frame_pos = POS_HEADER;
            end
         end else begin
            if (frame_pos == POS_CR && b == rfpa_pkg::CR_BYTE) begin
               if (frame_digits == rfpa_pkg::NO_TARGET_A ||
                   frame_digits == rfpa_pkg::NO_TARGET_B) begin
                  if (batch_no_target < MAX_FRAMES)
                     batch_no_target++;
               end else if (batch_valid < MAX_FRAMES) begin
                  batch_sum += {12'd0, frame_digits};
                  batch_valid++;
               end
            end
            frame_pos = POS_HEADER;
         end
         return 1'b0;
      end
      if (batch_valid != 0) begin
         quot = batch_sum / {14'd0, batch_valid};
         res.status = rfpa_pkg::STATUS_MEAN;
         res.distance_mm = quot[15:0];
      end else if (batch_no_target != 0) begin
         capped = {1'b0, max_range} + {1'b0, rfpa_pkg::NO_TARGET_ADD_MM};
         res.status = rfpa_pkg::STATUS_NO_TARGET;
         res.distance_mm = capped[16] ? '1 : capped[15:0];
      end else begin
         res.status = rfpa_pkg::STATUS_NONE;
      end
      batch_sum = '0;
      batch_valid = '0;
      batch_no_target = '0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      range_result_type got;
      range_result_type want;
      range_result_type predicted;
      if (reset) begin
         max_range = rfpa_pkg::MAX_RANGE_RESET;
         frame_pos = POS_HEADER;
         frame_digits = '0;
         batch_sum = '0;
         batch_valid = '0;
         batch_no_target = '0;
         pending_results.delete();
      end else begin
         if (csr_wr_en)
            max_range = csr_wr_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status = rsp_mon.status;
            got.distance_mm = rsp_mon.distance_mm;
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result status=%0d distance_mm=%0d",
                                         got.status, got.distance_mm));
            end else begin
               want = pending_results.pop_front();
               results_seen++;
               if (want.status == rfpa_pkg::STATUS_MEAN)
                  mean_results++;
               if (want.status == rfpa_pkg::STATUS_NO_TARGET)
                  no_target_results++;
               if (got.status != want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, want.status));
               if (got.distance_mm != want.distance_mm)
                  report_mismatch($sformatf("distance_mm %0d, expected %0d",
                                            got.distance_mm, want.distance_mm));
            end
         end
         if (req_mon.valid && req_mon.ready &&
             average_batch(req_mon.opcode, req_mon.rx_byte, predicted))
            pending_results.push_back(predicted);
      end
      outstanding = pending_results.size();
   end

endmodule

/* test/tb_range_frame_parser_averager.sv */
// Testbench top for the range frame parser and averager: clock, reset, byte
// and poll stimulus, result backpressure and the final verdict. Depends on the
// top level, rfpa_pkg, rfpa_req_if, rfpa_rsp_if and rfpa_result_checker.
module tb_range_frame_parser_averager;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_FRAMES   = 4095;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 24;
   localparam int PHASE_ITEMS  = 120;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   int mismatches;
   int outstanding;
   int results_seen;
   int mean_results;
   int no_target_results;

   int transfers = 0;
   int burst_left = 0;
   int gap_max = 6;
   bit hold_rsp = 1'b0;

   rfpa_req_if req();
   rfpa_rsp_if rsp();

   range_frame_parser_averager #(
      .MAX_FRAMES_PER_BATCH(MAX_FRAMES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req),
      .rsp_ch     (rsp),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   rfpa_result_checker #(
      .MAX_FRAMES(MAX_FRAMES)
   ) checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req),
      .rsp_mon          (rsp),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .results_seen     (results_seen),
      .mean_results     (mean_results),
      .no_target_results(no_target_results)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

   // Result side: changing stall pattern, plus one long counted hold-off.
   initial begin
      int cyc;
      int mode;
      cyc = 0;
      mode = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            if (cyc % 64 == 0)
               mode = int'($urandom_range(0, 3));
            case (mode)
               0: rsp.ready <= 1'b1;
               1: rsp.ready <= 1'($urandom_range(0, 1));
               2: rsp.ready <= (cyc % 4 == 3);
               default: rsp.ready <= ($urandom_range(0, 5) == 0);
            endcase
            cyc++;
         end
      end
   end

   task automatic offer(input logic op, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = int'($urandom_range(0, gap_max));
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = int'($urandom_range(1, 24));
      end
      req.valid <= 1'b1;
      req.opcode <= op;
      req.rx_byte <= b;
      do @(posedge clock); while (!req.ready);
      burst_left--;
      transfers++;
   endtask

   task automatic offer_text(input string s);
      for (int i = 0; i < s.len(); i++)
         offer(rfpa_pkg::OPCODE_BYTE, s[i]);
   endtask

   task automatic poll_batch();
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      offer(rfpa_pkg::OPCODE_POLL, junk);
   endtask

   task automatic send_frame(input int mm);
      int scale;
      logic [7:0] d;
      offer(rfpa_pkg::OPCODE_BYTE, rfpa_pkg::HEADER_BYTE);
      scale = 1000;
      repeat (4) begin
         d = 8'((mm / scale) % 10);
         offer(rfpa_pkg::OPCODE_BYTE, rfpa_pkg::DIGIT_LO + d);
         scale /= 10;
      end
      offer(rfpa_pkg::OPCODE_BYTE, rfpa_pkg::CR_BYTE);
   endtask

   // Header, some digits, then a byte that breaks the frame where it stands.
   task automatic send_broken_frame();
      int n_digits;
      logic [7:0] d;
      logic [7:0] bad;
      n_digits = int'($urandom_range(0, 4));
      offer(rfpa_pkg::OPCODE_BYTE, rfpa_pkg::HEADER_BYTE);
      repeat (n_digits) begin
         d = 8'($urandom_range(0, 9));
         offer(rfpa_pkg::OPCODE_BYTE, rfpa_pkg::DIGIT_LO + d);
      end
      do bad = 8'($urandom_range(0, 255));
      while (n_digits < 4 ? (bad >= rfpa_pkg::DIGIT_LO && bad <= rfpa_pkg::DIGIT_HI)
                          : (bad == rfpa_pkg::CR_BYTE));
      offer(rfpa_pkg::OPCODE_BYTE, bad);
   endtask

   task automatic idle_until_drained();
      req.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_max_range(input logic [15:0] value);
      idle_until_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_batches(input int quota);
      int stop_at;
      int kind;
      int n_frames;
      int pick;
      logic [7:0] noise;
      stop_at = transfers + quota;
      while (transfers < stop_at) begin
         kind = int'($urandom_range(0, 9));
         n_frames = int'($urandom_range(0, 5));
         repeat (n_frames) begin
            if ($urandom_range(0, 5) == 0) begin
               noise = 8'($urandom_range(0, 255));
               offer(rfpa_pkg::OPCODE_BYTE, noise);
            end
            pick = int'($urandom_range(0, 9));
            if (pick < 2) begin
               send_broken_frame();
            end else if (kind < 3) begin
               send_frame(pick < 6 ? int'(rfpa_pkg::NO_TARGET_A)
                                   : int'(rfpa_pkg::NO_TARGET_B));
            end else if (kind == 3) begin
               noise = 8'($urandom_range(0, 255));
               offer(rfpa_pkg::OPCODE_BYTE, noise);
            end else begin
               case (pick)
                  2: send_frame(int'(rfpa_pkg::NO_TARGET_A));
                  3: send_frame(int'(rfpa_pkg::NO_TARGET_B));
                  4: send_frame(0);
                  5: send_frame(9998);
                  default: send_frame(int'($urandom_range(0, 9999)));
               endcase
            end
         end
         poll_batch();
      end
   endtask

   initial begin
      req.valid <= 1'b0;
      req.opcode <= rfpa_pkg::OPCODE_BYTE;
      req.rx_byte <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty poll, poll inside a frame, bad terminator consumed,
      // header inside digits ignored, byte extremes
      poll_batch();
      offer_text("R99");
      poll_batch();
      offer_text("99");
      offer(rfpa_pkg::OPCODE_BYTE, rfpa_pkg::CR_BYTE);
      poll_batch();
      offer_text("R0000R");
      offer_text("R0000");
      offer(rfpa_pkg::OPCODE_BYTE, rfpa_pkg::CR_BYTE);
      offer_text("R1R");
      offer(rfpa_pkg::OPCODE_BYTE, 8'hFF);
      offer(rfpa_pkg::OPCODE_BYTE, 8'h00);
      poll_batch();

      set_max_range(16'd0);
      random_batches(PHASE_ITEMS);
      set_max_range(16'd60000);
      random_batches(PHASE_ITEMS);

      // long result hold-off with a full-rate sender
      set_max_range(16'($urandom_range(0, 60000)));
      gap_max = 0;
      hold_rsp = 1'b1;
      random_batches(PHASE_ITEMS);
      gap_max = 6;

      set_max_range(16'($urandom_range(0, 60000)));
      random_batches(PHASE_ITEMS);
      set_max_range(16'($urandom_range(0, 60000)));
      random_batches(PHASE_ITEMS);

      idle_until_drained();
      $display("Summary: %0d transfers in, %0d results checked (%0d mean, %0d no-target)",
               transfers, results_seen, mean_results, no_target_results);
      $display("Covered max range 0, 60000 and random, broken frames and a long result stall");
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* range_frame_parser_averager.f */
+incdir+rtl
rtl/rfpa_pkg.sv
rtl/rfpa_req_if.sv
rtl/rfpa_rsp_if.sv
rtl/rfpa_parser.sv
rtl/rfpa_datapath.sv
rtl/rfpa_ctrl.sv
rtl/range_frame_parser_averager.sv
test/rfpa_result_checker.sv
test/tb_range_frame_parser_averager.sv
